// File: design/bom_detecting_utf8_transcoder_defines.svh
// Assertion macros used by the checker file.
`ifndef BOM_DETECTING_UTF8_TRANSCODER_DEFINES_SVH
`define BOM_DETECTING_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, clocked and disabled while in reset
`define BDU8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDU8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bdu8_pkg.sv
`default_nettype none

package bdu8_pkg;

  typedef enum logic [2:0] {
    FMT_NONE  = 3'd0,
    FMT_UTF8  = 3'd1,
    FMT_U16LE = 3'd2,
    FMT_U16BE = 3'd3,
    FMT_U32LE = 3'd4,
    FMT_U32BE = 3'd5
  } fmt_e;

  localparam logic [31:0] CP_1B_MAX  = 32'h0000_007F;
  localparam logic [31:0] CP_2B_MAX  = 32'h0000_07FF;
  localparam logic [31:0] CP_3B_MAX  = 32'h0000_FFFF;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

  localparam logic [7:0] BOM8_0  = 8'hEF;
  localparam logic [7:0] BOM8_1  = 8'hBB;
  localparam logic [7:0] BOM8_2  = 8'hBF;
  localparam logic [7:0] BOM_FF  = 8'hFF;
  localparam logic [7:0] BOM_FE  = 8'hFE;
  localparam logic [7:0] BOM_00  = 8'h00;
  localparam logic [7:0] LEAD4   = 8'hF0;

  // one group of result bytes made by one input beat
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    fmt_e            fmt;
  } grp_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [31:0] cp);
    enc_t r;
    r.bytes = '0;
    if (cp <= CP_1B_MAX) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp <= CP_2B_MAX) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp <= CP_3B_MAX) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      // out-of-range values keep the truncated lead byte
      r.bytes[0] = LEAD4 | cp[25:18];
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/bom_detecting_utf8_transcoder.sv
// Path: the first result byte of a beat is registered in the core input stage, then in the
//   serializer group register, before it is on the output.
// Throughput: one input beat per cycle while each beat makes at most one byte and the
//   output is not stalled; a longer group holds later beats, set by the single byte-wide lane.
// Header bytes make no result until the fourth byte or the file end arrives.
// Reset: rst_ni asynchronous, active low, clears handshake and stream state; no clearing pass.
`default_nettype none

module bom_detecting_utf8_transcoder import bdu8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tuser,   // [0] file_start
  input  wire logic       s_axis_tlast,   // file_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,   // [2:0] detected_format
  output logic            m_axis_tlast    // run_last
);

  grp_t grp;
  logic grp_valid, grp_ready;

  bdu8_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .in_end_i    (s_axis_tlast),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  bdu8_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_i       (grp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_fmt_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: design/bdu8_core.sv
`default_nettype none

module bdu8_core import bdu8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_start_i,
  input  wire logic       in_end_i,
  output logic            grp_valid_o,
  input  wire logic       grp_ready_i,
  output grp_t            grp_o
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_start_q, in_end_q;

  logic [1:0]      hcnt_q, hcnt_d;
  logic [2:0][7:0] hb_q, hb_d;
  logic            dec_q, dec_d;
  fmt_e            fmt_q, fmt_d;
  logic [2:0][7:0] ub_q, ub_d;
  logic [1:0]      ufill_q, ufill_d;
  logic [9:0]      phigh_q, phigh_d;
  logic            pvalid_q, pvalid_d;

  logic            dec_c, pvalid_c;
  logic [1:0]      hcnt_c, ufill_c;
  fmt_e            fmt_c, det, fmt_out;
  logic [2:0]      n;
  logic [3:0][7:0] hv, pass_bytes;
  logic [2:0]      pass_cnt;
  logic            u16_go, enc_go;
  logic [15:0]     w16;
  logic [31:0]     cp;
  enc_t            enc;
  logic            adv;

  always_comb begin
    dec_c    = in_start_q ? 1'b0 : dec_q;
    fmt_c    = in_start_q ? FMT_NONE : fmt_q;
    hcnt_c   = in_start_q ? 2'd0 : hcnt_q;
    ufill_c  = in_start_q ? 2'd0 : ufill_q;
    pvalid_c = in_start_q ? 1'b0 : pvalid_q;

    for (int i = 0; i < 3; i++) begin
      hv[i] = (hcnt_c == 2'(i)) ? in_byte_q : hb_q[i];
    end
    hv[3] = in_byte_q;
    n = {1'b0, hcnt_c} + 3'd1;

    if (n >= 3'd3 && hv[0] == BOM8_0 && hv[1] == BOM8_1 && hv[2] == BOM8_2) begin
      det = FMT_UTF8;
    end else if (n == 3'd4 && hv[0] == BOM_FF && hv[1] == BOM_FE &&
                 hv[2] == BOM_00 && hv[3] == BOM_00) begin
      det = FMT_U32LE;
    end else if (n >= 3'd2 && hv[0] == BOM_FF && hv[1] == BOM_FE) begin
      det = FMT_U16LE;
    end else if (n >= 3'd2 && hv[0] == BOM_FE && hv[1] == BOM_FF) begin
      det = FMT_U16BE;
    end else if (n == 3'd4 && hv[0] == BOM_00 && hv[1] == BOM_00 &&
                 hv[2] == BOM_FE && hv[3] == BOM_FF) begin
      det = FMT_U32BE;
    end else begin
      det = FMT_NONE;
    end

    hcnt_d     = hcnt_c;
    hb_d       = hb_q;
    dec_d      = dec_c;
    fmt_d      = fmt_c;
    ub_d       = ub_q;
    ufill_d    = ufill_c;
    phigh_d    = phigh_q;
    pvalid_d   = pvalid_c;
    fmt_out    = fmt_c;
    pass_bytes = '0;
    pass_cnt   = 3'd0;
    u16_go     = 1'b0;
    w16        = '0;
    enc_go     = 1'b0;
    cp         = '0;

    if (!dec_c) begin
      for (int i = 0; i < 3; i++) begin
        if (hcnt_c == 2'(i)) hb_d[i] = in_byte_q;
      end
      hcnt_d = hcnt_c + 2'd1;
      if (n == 3'd4 || in_end_q) begin
        hcnt_d  = 2'd0;
        dec_d   = 1'b1;
        fmt_d   = det;
        fmt_out = det;
        case (det)
          FMT_NONE: begin
            pass_bytes = hv;
            pass_cnt   = n;
          end
          FMT_UTF8: begin
            if (n == 3'd4) begin
              pass_bytes[0] = hv[3];
              pass_cnt      = 3'd1;
            end
          end
          FMT_U16LE: begin
            u16_go = (n == 3'd4);
            w16    = {hv[3], hv[2]};
          end
          FMT_U16BE: begin
            u16_go = (n == 3'd4);
            w16    = {hv[2], hv[3]};
          end
          default: ;
        endcase
      end
    end else begin
      case (fmt_c)
        FMT_U16LE, FMT_U16BE: begin
          if (ufill_c == 2'd0) begin
            ub_d[0] = in_byte_q;
            ufill_d = 2'd1;
          end else begin
            ufill_d = 2'd0;
            u16_go  = 1'b1;
            w16     = (fmt_c == FMT_U16LE) ? {in_byte_q, ub_q[0]} : {ub_q[0], in_byte_q};
          end
        end
        FMT_U32LE, FMT_U32BE: begin
          if (ufill_c != 2'd3) begin
            for (int i = 0; i < 3; i++) begin
              if (ufill_c == 2'(i)) ub_d[i] = in_byte_q;
            end
            ufill_d = ufill_c + 2'd1;
          end else begin
            ufill_d = 2'd0;
            enc_go  = 1'b1;
            cp      = (fmt_c == FMT_U32LE) ? {in_byte_q, ub_q[2], ub_q[1], ub_q[0]}
                                           : {ub_q[0], ub_q[1], ub_q[2], in_byte_q};
          end
        end
        default: begin
          pass_bytes[0] = in_byte_q;
          pass_cnt      = 3'd1;
        end
      endcase
    end

    // surrogate pairing
    if (u16_go) begin
      pvalid_d = 1'b0;
      if (pvalid_c && w16 >= LO_SURR_LO && w16 <= LO_SURR_HI) begin
        enc_go = 1'b1;
        cp     = SUPP_BASE + {12'd0, phigh_q, w16[9:0]};
      end else if (w16 >= HI_SURR_LO && w16 <= HI_SURR_HI) begin
        phigh_d  = w16[9:0];
        pvalid_d = 1'b1;
      end else begin
        enc_go = 1'b1;
        cp     = {16'd0, w16};
      end
    end

    enc = utf8_encode(cp);

    grp_o.bytes = enc_go ? enc.bytes : pass_bytes;
    grp_o.cnt   = enc_go ? enc.cnt : pass_cnt;
    grp_o.fmt   = fmt_out;

    if (in_end_q) begin
      hcnt_d   = 2'd0;
      dec_d    = 1'b0;
      fmt_d    = FMT_NONE;
      ufill_d  = 2'd0;
      phigh_d  = '0;
      pvalid_d = 1'b0;
    end
  end

  assign grp_valid_o = in_valid_q && (grp_o.cnt != 3'd0);
  assign adv         = in_valid_q && ((grp_o.cnt == 3'd0) || grp_ready_i);
  assign in_ready_o  = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      hcnt_q     <= 2'd0;
      dec_q      <= 1'b0;
      fmt_q      <= FMT_NONE;
      ufill_q    <= 2'd0;
      phigh_q    <= '0;
      pvalid_q   <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (adv) begin
        hcnt_q   <= hcnt_d;
        dec_q    <= dec_d;
        fmt_q    <= fmt_d;
        ufill_q  <= ufill_d;
        phigh_q  <= phigh_d;
        pvalid_q <= pvalid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= in_byte_i;
      in_start_q <= in_start_i;
      in_end_q   <= in_end_i;
    end
    if (adv) begin
      hb_q <= hb_d;
      ub_q <= ub_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bdu8_serializer.sv
`default_nettype none

module bdu8_serializer import bdu8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       grp_valid_i,
  output logic            grp_ready_o,
  input  wire grp_t       grp_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      out_fmt_o,
  output logic            out_last_o
);

  grp_t       grp_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       fire, load;

  assign out_valid_o = valid_q;
  assign out_byte_o  = grp_q.bytes[idx_q];
  assign out_fmt_o   = grp_q.fmt;
  assign out_last_o  = ({1'b0, idx_q} == (grp_q.cnt - 3'd1));
  assign fire        = valid_q && out_ready_i;
  assign grp_ready_o = !valid_q || (fire && out_last_o);
  assign load        = grp_valid_i && grp_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= 2'd0;
      end else if (fire) begin
        if (out_last_o) begin
          valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

endmodule

`default_nettype wire

// File: design/bdu8_checker.sv
`default_nettype none
`include "bom_detecting_utf8_transcoder_defines.svh"

module bdu8_checker import bdu8_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  logic       m_beat;
  logic       multi;
  logic [2:0] run_cnt_q;

  assign m_beat = m_axis_tvalid && m_axis_tready;
  assign multi  = (m_axis_tuser == FMT_U16LE) || (m_axis_tuser == FMT_U16BE) ||
                  (m_axis_tuser == FMT_U32LE) || (m_axis_tuser == FMT_U32BE);

  // beats delivered so far in the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= 3'd0;
    end else if (m_beat) begin
      run_cnt_q <= m_axis_tlast ? 3'd0 : run_cnt_q + 3'd1;
    end
  end

  `BDU8_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
    $stable(m_axis_tlast), "output beat changed while stalled")
  `BDU8_ASSERT_NXT(a_run_cont, clk_i, rst_ni, m_beat && !m_axis_tlast,
    m_axis_tvalid && $stable(m_axis_tuser), "run broken or format changed mid-run")
  `BDU8_ASSERT_IMP(a_run_len, clk_i, rst_ni, m_beat, run_cnt_q < 3'd4,
    "run longer than four beats")
  `BDU8_ASSERT_NXT(a_cont_byte, clk_i, rst_ni, m_beat && !m_axis_tlast && multi,
    m_axis_tdata[7:6] == 2'b10, "encoded run lacks continuation byte")

endmodule

bind bom_detecting_utf8_transcoder bdu8_checker u_bdu8_checker (.*);

`default_nettype wire

// File: tb/tb_bom_detecting_utf8_transcoder.sv
`timescale 1ns / 100ps

module tb_bom_detecting_utf8_transcoder;
  import bdu8_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned DIRECTED_ROWS  = 31;

  typedef struct packed {
    logic [7:0]      data;
    logic            sof;
    logic            eof;
    logic            known;
    logic [2:0]      n_out;
    logic [3:0][7:0] out;
    fmt_e            fmt;
  } file_beat_t;

  typedef struct packed {
    logic [7:0] data;
    fmt_e       fmt;
    logic       last;
  } utf8_beat_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  bom_detecting_utf8_transcoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  file_beat_t  directed_tab [DIRECTED_ROWS];
  file_beat_t  stim_q [$];
  logic [7:0]  file_bytes [$];
  utf8_beat_t  expected_utf8_q [$];
  file_beat_t  drv_beat;
  int unsigned mismatches  = 0;
  int unsigned beats_seen  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done   = 1'b0;

  // transcoder state mirror
  logic [2:0]      hdr_cnt;
  logic [3:0][7:0] hdr_buf;
  logic            fmt_known;
  fmt_e            cur_fmt;
  logic [2:0][7:0] unit_buf;
  logic [1:0]      unit_cnt;
  logic [9:0]      hi_surr;
  logic            hi_surr_vld;
  logic [3:0][7:0] step_out;
  int unsigned     step_n;
  fmt_e            step_fmt;

  function automatic file_beat_t plain_beat(logic [7:0] d, logic sof, logic eof);
    file_beat_t b;
    b      = '0;
    b.data = d;
    b.sof  = sof;
    b.eof  = eof;
    return b;
  endfunction

  function automatic file_beat_t known_beat(logic [7:0] d, logic sof, logic eof,
                                            logic [2:0] n, logic [31:0] out, fmt_e f);
    file_beat_t b;
    b       = plain_beat(d, sof, eof);
    b.known = 1'b1;
    b.n_out = n;
    b.out   = out;
    b.fmt   = f;
    return b;
  endfunction

  task automatic add_file_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  task automatic add_stim(input file_beat_t b);
    stim_q = {stim_q, b};
  endtask

  task automatic add_expected(input logic [7:0] d, input fmt_e f, input logic last);
    utf8_beat_t e;
    e.data          = d;
    e.fmt           = f;
    e.last          = last;
    expected_utf8_q = {expected_utf8_q, e};
  endtask

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_stream_state();
    hdr_cnt     = '0;
    hdr_buf     = '0;
    fmt_known   = 1'b0;
    cur_fmt     = FMT_NONE;
    unit_buf    = '0;
    unit_cnt    = '0;
    hi_surr     = '0;
    hi_surr_vld = 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    if (step_n < 4) begin
      step_out[step_n] = b;
      step_n++;
    end
  endtask

  task automatic emit_code_point(input logic [31:0] cp);
    if (cp <= CP_1B_MAX) begin
      put_byte(cp[7:0]);
    end else if (cp <= CP_2B_MAX) begin
      put_byte(8'hC0 | {3'b000, cp[10:6]});
      put_byte(8'h80 | {2'b00, cp[5:0]});
    end else if (cp <= CP_3B_MAX) begin
      put_byte(8'hE0 | {4'h0, cp[15:12]});
      put_byte(8'h80 | {2'b00, cp[11:6]});
      put_byte(8'h80 | {2'b00, cp[5:0]});
    end else begin
      put_byte(8'hF0 | cp[25:18]);
      put_byte(8'h80 | {2'b00, cp[17:12]});
      put_byte(8'h80 | {2'b00, cp[11:6]});
      put_byte(8'h80 | {2'b00, cp[5:0]});
    end
  endtask

  task automatic take_utf16_unit(input logic [15:0] w);
    logic paired;
    paired = 1'b0;
    if (hi_surr_vld) begin
      hi_surr_vld = 1'b0;
      if (w >= LO_SURR_LO && w <= LO_SURR_HI) begin
        emit_code_point(SUPP_BASE + {12'h000, hi_surr, w[9:0]});
        paired = 1'b1;
      end
    end
    if (!paired) begin
      if (w >= HI_SURR_LO && w <= HI_SURR_HI) begin
        hi_surr     = w[9:0];
        hi_surr_vld = 1'b1;
      end else begin
        emit_code_point({16'h0000, w});
      end
    end
  endtask

  task automatic feed_stream_byte(input logic [7:0] b);
    case (cur_fmt)
      FMT_U16LE, FMT_U16BE: begin
        if (unit_cnt == 2'd0) begin
          unit_buf[0] = b;
          unit_cnt    = 2'd1;
        end else begin
          unit_cnt = 2'd0;
          take_utf16_unit(cur_fmt == FMT_U16LE ? {b, unit_buf[0]} : {unit_buf[0], b});
        end
      end
      FMT_U32LE, FMT_U32BE: begin
        if (unit_cnt != 2'd3) begin
          unit_buf[unit_cnt] = b;
          unit_cnt           = unit_cnt + 2'd1;
        end else begin
          unit_cnt = 2'd0;
          emit_code_point(cur_fmt == FMT_U32LE ?
                          {b, unit_buf[2], unit_buf[1], unit_buf[0]} :
                          {unit_buf[0], unit_buf[1], unit_buf[2], b});
        end
      end
      default: begin
        put_byte(b);
      end
    endcase
  endtask

  task automatic resolve_header();
    fmt_e        f;
    int unsigned skip;
    f = FMT_NONE;
    if (hdr_cnt >= 3'd3 && hdr_buf[0] == BOM8_0 && hdr_buf[1] == BOM8_1 &&
        hdr_buf[2] == BOM8_2)
      f = FMT_UTF8;
    else if (hdr_cnt >= 3'd4 && hdr_buf[0] == BOM_FF && hdr_buf[1] == BOM_FE &&
             hdr_buf[2] == BOM_00 && hdr_buf[3] == BOM_00)
      f = FMT_U32LE;
    else if (hdr_cnt >= 3'd2 && hdr_buf[0] == BOM_FF && hdr_buf[1] == BOM_FE)
      f = FMT_U16LE;
    else if (hdr_cnt >= 3'd2 && hdr_buf[0] == BOM_FE && hdr_buf[1] == BOM_FF)
      f = FMT_U16BE;
    else if (hdr_cnt >= 3'd4 && hdr_buf[0] == BOM_00 && hdr_buf[1] == BOM_00 &&
             hdr_buf[2] == BOM_FE && hdr_buf[3] == BOM_FF)
      f = FMT_U32BE;
    cur_fmt   = f;
    fmt_known = 1'b1;
    case (f)
      FMT_NONE:             skip = 0;
      FMT_UTF8:             skip = 3;
      FMT_U16LE, FMT_U16BE: skip = 2;
      default:              skip = 4;
    endcase
    for (int unsigned i = skip; i < hdr_cnt; i++) feed_stream_byte(hdr_buf[i]);
  endtask

  task automatic transcode_byte(input logic [7:0] d, input logic sof, input logic eof);
    step_n = 0;
    if (sof) clear_stream_state();
    if (!fmt_known) begin
      hdr_buf[hdr_cnt[1:0]] = d;
      hdr_cnt               = hdr_cnt + 3'd1;
      if (hdr_cnt >= 3'd4 || eof) resolve_header();
    end else begin
      feed_stream_byte(d);
    end
    step_fmt = cur_fmt;
    if (eof) clear_stream_state();
  endtask

  task automatic push_mark(input fmt_e f);
    case (f)
      FMT_UTF8: begin
        add_file_byte(BOM8_0);
        add_file_byte(BOM8_1);
        add_file_byte(BOM8_2);
      end
      FMT_U16LE: begin
        add_file_byte(BOM_FF);
        add_file_byte(BOM_FE);
      end
      FMT_U16BE: begin
        add_file_byte(BOM_FE);
        add_file_byte(BOM_FF);
      end
      FMT_U32LE: begin
        add_file_byte(BOM_FF);
        add_file_byte(BOM_FE);
        add_file_byte(BOM_00);
        add_file_byte(BOM_00);
      end
      FMT_U32BE: begin
        add_file_byte(BOM_00);
        add_file_byte(BOM_00);
        add_file_byte(BOM_FE);
        add_file_byte(BOM_FF);
      end
      default: ;
    endcase
  endtask

  task automatic push_unit(input fmt_e f, input logic [31:0] v);
    case (f)
      FMT_U16LE: begin
        add_file_byte(v[7:0]);
        add_file_byte(v[15:8]);
      end
      FMT_U16BE: begin
        add_file_byte(v[15:8]);
        add_file_byte(v[7:0]);
      end
      FMT_U32LE: begin
        add_file_byte(v[7:0]);
        add_file_byte(v[15:8]);
        add_file_byte(v[23:16]);
        add_file_byte(v[31:24]);
      end
      default: begin
        add_file_byte(v[31:24]);
        add_file_byte(v[23:16]);
        add_file_byte(v[15:8]);
        add_file_byte(v[7:0]);
      end
    endcase
  endtask

  // mostly well-formed files with random content, some broken headers and noise
  task automatic build_random_files(input int unsigned n_items);
    int unsigned target, r, n, cut;
    logic [31:0] rnd;
    fmt_e        f;
    bit          noise, with_sof, with_eof;
    target = stim_q.size() + n_items;
    while (stim_q.size() < target) begin
      r     = $urandom_range(0, 13);
      noise = ($urandom_range(0, 9) == 0);
      f     = (r <= 2) ? FMT_NONE : (r == 3) ? FMT_UTF8 : (r <= 6) ? FMT_U16LE :
              (r <= 9) ? FMT_U16BE : (r <= 11) ? FMT_U32LE : FMT_U32BE;
      file_bytes.delete();
      push_mark(f);
      if (noise) begin
        cut = $urandom_range(0, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        repeat ($urandom_range(1, 6)) begin
          rnd = $urandom;
          add_file_byte(rnd[7:0]);
        end
        for (int k = 0; k < file_bytes.size(); k++)
          add_stim(plain_beat(file_bytes[k], $urandom_range(0, 5) == 0,
                              $urandom_range(0, 4) == 0));
      end else begin
        n = $urandom_range(0, 8);
        case (f)
          FMT_U16LE, FMT_U16BE: begin
            repeat (n) begin
              r = $urandom_range(0, 9);
              if (r <= 2) push_unit(f, $urandom_range(0, 'h7F));
              else if (r == 3) push_unit(f, $urandom_range('h80, 'h7FF));
              else if (r == 4) push_unit(f, $urandom_range('h800, 'hFFFF));
              else if (r <= 6) begin
                push_unit(f, $urandom_range('hD800, 'hDBFF));
                push_unit(f, $urandom_range('hDC00, 'hDFFF));
              end else if (r == 7) push_unit(f, $urandom_range('hD800, 'hDBFF));
              else if (r == 8) push_unit(f, $urandom_range('hDC00, 'hDFFF));
              else push_unit(f, $urandom & 32'h0000_FFFF);
            end
          end
          FMT_U32LE, FMT_U32BE: begin
            repeat (n) begin
              r = $urandom_range(0, 7);
              if (r <= 1) push_unit(f, $urandom_range(0, 'h7F));
              else if (r == 2) push_unit(f, $urandom_range('h80, 'h7FF));
              else if (r == 3) push_unit(f, $urandom_range('h800, 'hFFFF));
              else if (r <= 5) push_unit(f, $urandom_range('h10000, 'h10FFFF));
              else if (r == 6) push_unit(f, $urandom);
              else push_unit(f, $urandom_range('hD800, 'hDFFF));
            end
          end
          default: begin
            repeat (n) begin
              rnd = $urandom;
              add_file_byte(rnd[7:0]);
            end
          end
        endcase
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3))
            if (file_bytes.size() != 0) void'(file_bytes.pop_back());
        with_sof = ($urandom_range(0, 9) != 0);
        with_eof = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < file_bytes.size(); k++)
          add_stim(plain_beat(file_bytes[k], with_sof && k == 0,
                              with_eof && k == file_bytes.size() - 1));
      end
    end
  endtask

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    utf8_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        transcode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        if (drv_beat.known) begin
          for (int k = 0; k < drv_beat.n_out; k++)
            add_expected(drv_beat.out[k], drv_beat.fmt, k == drv_beat.n_out - 1);
        end else begin
          for (int k = 0; k < step_n; k++)
            add_expected(step_out[k], step_fmt, k == step_n - 1);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (expected_utf8_q.size() == 0) begin
          $error("unexpected beat: out_byte %h detected_format %0d run_last %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_utf8_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.fmt) begin
            $error("detected_format: expected %0d, actual %0d", want.fmt, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // output side: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned stall;
    bit          calm;
    stall = 0;
    calm  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && beats_seen >= 150) begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 63) == 0) calm = !calm;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap(1'b0);
      end
    end
  end

  initial begin
    int unsigned gap;
    bit          calm;
    calm     = 1'b0;
    drv_beat = '0;
    clear_stream_state();

    // no-mark flush at file end, then a file that follows an end without a start
    directed_tab[0]  = known_beat(8'h00, 1'b1, 1'b1, 3'd1, 32'h0000_0000, FMT_NONE);
    directed_tab[1]  = plain_beat(8'hEF, 1'b0, 1'b0);
    directed_tab[2]  = plain_beat(8'hBB, 1'b0, 1'b0);
    directed_tab[3]  = plain_beat(8'hBF, 1'b0, 1'b0);
    directed_tab[4]  = known_beat(8'hFF, 1'b0, 1'b1, 3'd1, 32'h0000_00FF, FMT_UTF8);
    // utf16 be: pair, high then plain unit, lone low, trailing byte
    directed_tab[5]  = plain_beat(8'hFE, 1'b1, 1'b0);
    directed_tab[6]  = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[7]  = plain_beat(8'hD8, 1'b0, 1'b0);
    directed_tab[8]  = plain_beat(8'h00, 1'b0, 1'b0);
    directed_tab[9]  = plain_beat(8'hDF, 1'b0, 1'b0);
    directed_tab[10] = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[11] = plain_beat(8'hDB, 1'b0, 1'b0);
    directed_tab[12] = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[13] = plain_beat(8'h00, 1'b0, 1'b0);
    directed_tab[14] = plain_beat(8'h41, 1'b0, 1'b0);
    directed_tab[15] = plain_beat(8'hDC, 1'b0, 1'b0);
    directed_tab[16] = known_beat(8'h00, 1'b0, 1'b0, 3'd3, 32'h0080_B0ED, FMT_U16BE);
    directed_tab[17] = plain_beat(8'h7A, 1'b0, 1'b0);
    // restart mid-file into utf16 le; waiting high surrogate dropped at end
    directed_tab[18] = plain_beat(8'hFF, 1'b1, 1'b0);
    directed_tab[19] = plain_beat(8'hFE, 1'b0, 1'b0);
    directed_tab[20] = plain_beat(8'h00, 1'b0, 1'b0);
    directed_tab[21] = plain_beat(8'hD8, 1'b0, 1'b1);
    // utf32 le: out-of-range word, then a partial word at end
    directed_tab[22] = plain_beat(8'hFF, 1'b1, 1'b0);
    directed_tab[23] = plain_beat(8'hFE, 1'b0, 1'b0);
    directed_tab[24] = plain_beat(8'h00, 1'b0, 1'b0);
    directed_tab[25] = plain_beat(8'h00, 1'b0, 1'b0);
    directed_tab[26] = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[27] = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[28] = plain_beat(8'hFF, 1'b0, 1'b0);
    directed_tab[29] = known_beat(8'hFF, 1'b0, 1'b0, 3'd4, 32'hBFBF_BFFF, FMT_U32LE);
    directed_tab[30] = plain_beat(8'h12, 1'b0, 1'b1);

    for (int i = 0; i < DIRECTED_ROWS; i++) add_stim(directed_tab[i]);
    build_random_files(RANDOM_ITEMS);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = pick_gap(calm);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      drv_beat = stim_q[i];
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= drv_beat.data;
      s_axis_tuser  <= drv_beat.sof;
      s_axis_tlast  <= drv_beat.eof;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_utf8_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: bom_detecting_utf8_transcoder.f
+incdir+design
design/bdu8_pkg.sv
design/bdu8_core.sv
design/bdu8_serializer.sv
design/bom_detecting_utf8_transcoder.sv
design/bdu8_checker.sv
tb/tb_bom_detecting_utf8_transcoder.sv
